FILE: hdl/bimc_pkg.sv
`default_nettype none

package bimc_pkg;

	// Field widths of the result
	localparam int AREA_W = 21;
	localparam int SUM_W  = 30;
	localparam int MOM_W  = 39;
	localparam int CTR_W  = 11;

	// Configuration port
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

	// Pixel value that marks an object pixel
	localparam logic [7:0] OBJECT_VALUE = 8'd255;

	// One quotient bit per step over the whole dividend
	localparam int DIV_STEPS = SUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Commands from the controller to the datapath
	typedef struct packed {
		logic acc_en;
		logic snap;
		logic div_step;
	} bimc_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic frame_end;
	} bimc_sts_t;

endpackage

`default_nettype wire

FILE: hdl/bimc_ctrl.sv
`default_nettype none

module bimc_ctrl
	import bimc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      pixel_valid,
	output logic           pixel_stall,
	output logic           result_valid,
	input  wire logic      result_stall,
	input  wire bimc_sts_t sts,
	output bimc_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

	state_t               state_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	// Hold a frame-end pixel while the previous result is still in flight
	assign pixel_stall = sts.frame_end && (state_q != S_IDLE);
	assign result_valid = (state_q == S_OUT);

	always_comb begin
		cmd.acc_en   = pixel_valid && !pixel_stall;
		cmd.snap     = pixel_valid && !pixel_stall && sts.frame_end;
		cmd.div_step = (state_q == S_DIV);
	end

	// Sequence snapshot, division and result hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (cmd.snap) state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_STEP) state_q <= S_OUT;
				end
				S_OUT: begin
					if (!result_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_snap_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.snap |-> (state_q == S_IDLE))
		else $error("frame snapshot taken while a result is in flight");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == LAST_STEP) |=> (state_q == S_OUT))
		else $error("division did not finish after its last step");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && result_stall) |=> (state_q == S_OUT))
		else $error("stalled result request dropped");
`endif

endmodule

`default_nettype wire

FILE: hdl/bimc_dp.sv
`default_nettype none

module bimc_dp
	import bimc_pkg::*;
#(
	parameter int MAX_DIM = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic [7:0]           pixel,
	input  wire bimc_cmd_t            cmd,
	output bimc_sts_t                 sts,
	output logic [AREA_W-1:0]         area,
	output logic [SUM_W-1:0]          sum_x,
	output logic [SUM_W-1:0]          sum_y,
	output logic [MOM_W-1:0]          sum_xy,
	output logic [MOM_W-1:0]          sum_xx,
	output logic [MOM_W-1:0]          sum_yy,
	output logic [CTR_W-1:0]          center_x,
	output logic [CTR_W-1:0]          center_y,
	output logic                      empty_frame
);

	localparam int CW = $clog2(MAX_DIM);
	localparam int XW = CW + 1;

	logic [CFG_W-1:0] width_q, height_q;
	logic [CW-1:0]    col_q, row_q;
	logic [XW-1:0]    w_eff, h_eff, x, y;
	logic [2*XW-1:0]  prod_xy, prod_xx, prod_yy;
	logic             obj, row_end;

	logic [AREA_W-1:0] acc_area_q, nxt_area;
	logic [SUM_W-1:0]  acc_x_q, acc_y_q, nxt_x, nxt_y;
	logic [MOM_W-1:0]  acc_xy_q, acc_xx_q, acc_yy_q, nxt_xy, nxt_xx, nxt_yy;

	logic [AREA_W-1:0] area_q;
	logic [SUM_W-1:0]  sum_x_q, sum_y_q;
	logic [MOM_W-1:0]  sum_xy_q, sum_xx_q, sum_yy_q;

	logic [AREA_W-1:0] rem_x_q, rem_y_q;
	logic [SUM_W-1:0]  quo_x_q, quo_y_q;
	logic [AREA_W:0]   trial_x, trial_y;
	logic              take_x, take_y;

	// Clamp a size register to 1..MAX_DIM
	function automatic logic [XW-1:0] eff_size(input logic [CFG_W-1:0] r);
		logic [XW-1:0] s;
		if (r == '0) s = XW'(1);
		else if (32'(r) > 32'(MAX_DIM)) s = XW'(MAX_DIM);
		else s = XW'(r);
		return s;
	endfunction

	// Write size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= FRAME_WIDTH_RST;
			height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Locate the current pixel and its moment terms
	always_comb begin
		w_eff   = eff_size(width_q);
		h_eff   = eff_size(height_q);
		x       = XW'(col_q) + 1'b1;
		y       = XW'(row_q) + 1'b1;
		obj     = (pixel == OBJECT_VALUE);
		row_end = (x >= w_eff);
		sts.frame_end = row_end && (y >= h_eff);
		prod_xy = x * y;
		prod_xx = x * x;
		prod_yy = y * y;
	end

	// Running moments including the current pixel
	always_comb begin
		nxt_area = acc_area_q;
		nxt_x    = acc_x_q;
		nxt_y    = acc_y_q;
		nxt_xy   = acc_xy_q;
		nxt_xx   = acc_xx_q;
		nxt_yy   = acc_yy_q;
		if (obj) begin
			nxt_area = acc_area_q + 1'b1;
			nxt_x    = acc_x_q + SUM_W'(x);
			nxt_y    = acc_y_q + SUM_W'(y);
			nxt_xy   = acc_xy_q + MOM_W'(prod_xy);
			nxt_xx   = acc_xx_q + MOM_W'(prod_xx);
			nxt_yy   = acc_yy_q + MOM_W'(prod_yy);
		end
	end

	// Advance raster position and accumulate; clear at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			acc_area_q <= '0;
			acc_x_q    <= '0;
			acc_y_q    <= '0;
			acc_xy_q   <= '0;
			acc_xx_q   <= '0;
			acc_yy_q   <= '0;
		end else if (cmd.acc_en) begin
			if (sts.frame_end) begin
				col_q      <= '0;
				row_q      <= '0;
				acc_area_q <= '0;
				acc_x_q    <= '0;
				acc_y_q    <= '0;
				acc_xy_q   <= '0;
				acc_xx_q   <= '0;
				acc_yy_q   <= '0;
			end else begin
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
				acc_area_q <= nxt_area;
				acc_x_q    <= nxt_x;
				acc_y_q    <= nxt_y;
				acc_xy_q   <= nxt_xy;
				acc_xx_q   <= nxt_xx;
				acc_yy_q   <= nxt_yy;
			end
		end
	end

	// Restoring division, one quotient bit per step
	always_comb begin
		trial_x = {rem_x_q, quo_x_q[SUM_W-1]};
		trial_y = {rem_y_q, quo_y_q[SUM_W-1]};
		take_x  = (trial_x >= {1'b0, area_q});
		take_y  = (trial_y >= {1'b0, area_q});
	end

	// Capture the frame's moments and run the centroid division
	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			area_q   <= nxt_area;
			sum_x_q  <= nxt_x;
			sum_y_q  <= nxt_y;
			sum_xy_q <= nxt_xy;
			sum_xx_q <= nxt_xx;
			sum_yy_q <= nxt_yy;
			rem_x_q  <= '0;
			rem_y_q  <= '0;
			quo_x_q  <= nxt_x;
			quo_y_q  <= nxt_y;
		end else if (cmd.div_step) begin
			rem_x_q <= take_x ? AREA_W'(trial_x - {1'b0, area_q}) : AREA_W'(trial_x);
			rem_y_q <= take_y ? AREA_W'(trial_y - {1'b0, area_q}) : AREA_W'(trial_y);
			quo_x_q <= {quo_x_q[SUM_W-2:0], take_x};
			quo_y_q <= {quo_y_q[SUM_W-2:0], take_y};
		end
	end

	// Drive the result fields
	always_comb begin
		area        = area_q;
		sum_x       = sum_x_q;
		sum_y       = sum_y_q;
		sum_xy      = sum_xy_q;
		sum_xx      = sum_xx_q;
		sum_yy      = sum_yy_q;
		empty_frame = (area_q == '0);
		center_x    = empty_frame ? '0 : quo_x_q[CTR_W-1:0];
		center_y    = empty_frame ? '0 : quo_y_q[CTR_W-1:0];
	end

endmodule

`default_nettype wire

FILE: hdl/binary_image_moments_centroid.sv
// Raw second-order moments and integer centroid of a binary frame.
// Pixel channel: pixel_valid/pixel_stall carry one 8-bit pixel per request in
// raster order; a pixel equal to 255 is an object pixel, coordinates start at 1.
// Result channel: result_valid/result_stall carry one request per frame with
// M00, M10, M01, M11, M20, M02, the truncated centroid and an empty-frame flag
// (centroid 0 when the frame holds no object pixel).
// Configuration: cfg_valid/cfg_ready write frame_width (index 0) or
// frame_height (index 1); cfg_ready is always high. Write only while idle.
// Throughput: one pixel per cycle. The frame's last pixel starts two restoring
// dividers, one per axis with the area as common divisor, that each yield one
// quotient bit per cycle until the whole dividend is done. The next frame is
// accumulated meanwhile; only its last pixel is stalled until the previous
// result has been taken, so frames shorter than about 32 pixels slow down.
// Reset clears the raster position and the moments and loads 640 x 480.
// While result_stall is high the result holds and nothing is lost.
`default_nettype none

module binary_image_moments_centroid
	import bimc_pkg::*;
#(
	parameter int MAX_DIM = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 pixel_valid,
	output logic                      pixel_stall,
	input  wire logic [7:0]           pixel,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic [AREA_W-1:0]         area,
	output logic [SUM_W-1:0]          sum_x,
	output logic [SUM_W-1:0]          sum_y,
	output logic [MOM_W-1:0]          sum_xy,
	output logic [MOM_W-1:0]          sum_xx,
	output logic [MOM_W-1:0]          sum_yy,
	output logic [CTR_W-1:0]          center_x,
	output logic [CTR_W-1:0]          center_y,
	output logic                      empty_frame,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	bimc_cmd_t cmd;
	bimc_sts_t sts;

	// Accept configuration writes at any time
	assign cfg_ready = 1'b1;

	bimc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	bimc_dp #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel       (pixel),
		.cmd         (cmd),
		.sts         (sts),
		.area        (area),
		.sum_x       (sum_x),
		.sum_y       (sum_y),
		.sum_xy      (sum_xy),
		.sum_xx      (sum_xx),
		.sum_yy      (sum_yy),
		.center_x    (center_x),
		.center_y    (center_y),
		.empty_frame (empty_frame)
	);

endmodule

`default_nettype wire

FILE: sim/tb_binary_image_moments_centroid.sv
`default_nettype none

module tb_binary_image_moments_centroid;
	import bimc_pkg::*;

	localparam int FRAME_DIM_MAX = 1024;
	localparam int DRAIN_CYCLES  = 48;
	localparam int HOLD_CYCLES   = 300;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	// Moments and centroid of one finished frame
	typedef struct {
		logic [AREA_W-1:0] area;
		logic [SUM_W-1:0]  sum_x;
		logic [SUM_W-1:0]  sum_y;
		logic [MOM_W-1:0]  sum_xy;
		logic [MOM_W-1:0]  sum_xx;
		logic [MOM_W-1:0]  sum_yy;
		logic [CTR_W-1:0]  center_x;
		logic [CTR_W-1:0]  center_y;
		logic              empty_frame;
	} frame_moments_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pixel_valid = 1'b0;
	logic pixel_stall;
	logic [7:0] pixel = 8'd0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [AREA_W-1:0] area;
	logic [SUM_W-1:0] sum_x;
	logic [SUM_W-1:0] sum_y;
	logic [MOM_W-1:0] sum_xy;
	logic [MOM_W-1:0] sum_xx;
	logic [MOM_W-1:0] sum_yy;
	logic [CTR_W-1:0] center_x;
	logic [CTR_W-1:0] center_y;
	logic empty_frame;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	// Raster position, running moments and size registers of the frame model
	logic [CFG_W-1:0] frame_w_cfg = FRAME_WIDTH_RST;
	logic [CFG_W-1:0] frame_h_cfg = FRAME_HEIGHT_RST;
	logic [9:0] col_pos = '0;
	logic [9:0] row_pos = '0;
	logic [AREA_W-1:0] m00 = '0;
	logic [SUM_W-1:0] m10 = '0;
	logic [SUM_W-1:0] m01 = '0;
	logic [MOM_W-1:0] m11 = '0;
	logic [MOM_W-1:0] m20 = '0;
	logic [MOM_W-1:0] m02 = '0;

	logic [7:0] pixel_backlog[$];
	frame_moments_t pending_moments[$];
	int unsigned pixels_queued = 0;
	int unsigned pixels_taken = 0;
	int unsigned fail_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;

	binary_image_moments_centroid u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.area         (area),
		.sum_x        (sum_x),
		.sum_y        (sum_y),
		.sum_xy       (sum_xy),
		.sum_xx       (sum_xx),
		.sum_yy       (sum_yy),
		.center_x     (center_x),
		.center_y     (center_y),
		.empty_frame  (empty_frame),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Clamp a size register to the range the block honors
	function automatic int clamp_size(input logic [CFG_W-1:0] reg_val);
		if (reg_val == '0)
			return 1;
		if (int'(reg_val) > FRAME_DIM_MAX)
			return FRAME_DIM_MAX;
		return int'(reg_val);
	endfunction

	// Advance the frame model by one pixel; queue the moments on the frame's last pixel
	task automatic accumulate_pixel(input logic [7:0] px);
		logic [MOM_W-1:0] xc;
		logic [MOM_W-1:0] yc;
		logic row_done;
		logic frame_done;
		frame_moments_t res;
		xc = MOM_W'(col_pos) + 1'b1;
		yc = MOM_W'(row_pos) + 1'b1;
		if (px == OBJECT_VALUE) begin
			m00 = m00 + 1'b1;
			m10 = m10 + SUM_W'(xc);
			m01 = m01 + SUM_W'(yc);
			m11 = m11 + xc * yc;
			m20 = m20 + xc * xc;
			m02 = m02 + yc * yc;
		end
		row_done = (int'(col_pos) + 1 >= clamp_size(frame_w_cfg));
		frame_done = row_done && (int'(row_pos) + 1 >= clamp_size(frame_h_cfg));
		if (!frame_done) begin
			if (row_done) begin
				col_pos = '0;
				row_pos = row_pos + 1'b1;
			end else begin
				col_pos = col_pos + 1'b1;
			end
		end else begin
			res.area = m00;
			res.sum_x = m10;
			res.sum_y = m01;
			res.sum_xy = m11;
			res.sum_xx = m20;
			res.sum_yy = m02;
			if (m00 == '0) begin
				res.center_x = '0;
				res.center_y = '0;
				res.empty_frame = 1'b1;
			end else begin
				res.center_x = CTR_W'(m10 / m00);
				res.center_y = CTR_W'(m01 / m00);
				res.empty_frame = 1'b0;
			end
			pending_moments.push_back(res);
			col_pos = '0;
			row_pos = '0;
			m00 = '0;
			m10 = '0;
			m01 = '0;
			m11 = '0;
			m20 = '0;
			m02 = '0;
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	// Pixel driver: offer the next request once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid <= 1'b0;
			pixel <= 8'd0;
		end else begin
			if (pixel_valid && !pixel_stall) begin
				accumulate_pixel(pixel);
				pixels_taken++;
			end
			if (!pixel_valid || !pixel_stall) begin
				if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					pixel_valid <= 1'b1;
					pixel <= pixel_backlog.pop_front();
				end else begin
					pixel_valid <= 1'b0;
					pixel <= 8'($urandom);
				end
			end
		end
	end

	// Result monitor: compare each taken request, then pick the next stall
	always @(posedge clk or negedge arst_n) begin
		frame_moments_t exp_r;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (pending_moments.size() == 0) begin
					$error("result request with no frame pending");
					fail_count++;
				end else begin
					exp_r = pending_moments.pop_front();
					check_field("area", 64'(exp_r.area), 64'(area));
					check_field("sum_x", 64'(exp_r.sum_x), 64'(sum_x));
					check_field("sum_y", 64'(exp_r.sum_y), 64'(sum_y));
					check_field("sum_xy", 64'(exp_r.sum_xy), 64'(sum_xy));
					check_field("sum_xx", 64'(exp_r.sum_xx), 64'(sum_xx));
					check_field("sum_yy", 64'(exp_r.sum_yy), 64'(sum_yy));
					check_field("center_x", 64'(exp_r.center_x), 64'(center_x));
					check_field("center_y", 64'(exp_r.center_y), 64'(center_y));
					check_field("empty_frame", 64'(exp_r.empty_frame), 64'(empty_frame));
				end
			end
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			// Hold off for a long stretch when asked, else stall at random
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Write one register; leave valid high so back-to-back writes stay clean
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_FRAME_WIDTH:  frame_w_cfg = val;
			REG_FRAME_HEIGHT: frame_h_cfg = val;
			default: ;
		endcase
	endtask

	task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		// Unused indexes must leave both sizes alone
		if ($urandom_range(3) == 0)
			write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic push_pixel(input logic [7:0] px);
		pixel_backlog.push_back(px);
		pixels_queued++;
	endtask

	// Queue one whole frame at the current size; a negative density picks one
	task automatic queue_frame(input int density);
		int dens;
		int npix;
		dens = density;
		if (dens < 0) begin
			case ($urandom_range(5))
				0: dens = 0;
				1: dens = 100;
				default: dens = $urandom_range(1, 99);
			endcase
		end
		npix = clamp_size(frame_w_cfg) * clamp_size(frame_h_cfg);
		repeat (npix) begin
			if ($urandom_range(99) < dens)
				push_pixel(OBJECT_VALUE);
			else
				push_pixel(8'($urandom_range(0, 254)));
		end
	endtask

	// Wait until every pixel is taken and every frame result has come back
	task automatic wait_idle();
		while (pixels_taken != pixels_queued || pending_moments.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// Batches of small frames, a new size for each batch
	task automatic random_frames(input int pixel_budget);
		int sent;
		int w;
		int h;
		sent = 0;
		while (sent < pixel_budget) begin
			case ($urandom_range(9))
				0: begin
					w = $urandom_range(0, 1);
					h = $urandom_range(0, 4);
				end
				1: begin
					w = $urandom_range(9, 40);
					h = $urandom_range(1, 2);
				end
				default: begin
					w = $urandom_range(1, 8);
					h = $urandom_range(1, 6);
				end
			endcase
			set_frame(CFG_W'(w), CFG_W'(h));
			repeat ($urandom_range(1, 6)) begin
				queue_frame(-1);
				sent += clamp_size(frame_w_cfg) * clamp_size(frame_h_cfg);
			end
			wait_idle();
		end
	endtask

	initial begin
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 22;
		recv_idle_pct = 58;

		// Single-pixel frames: object, background, value just below object
		set_frame(CFG_W'(1), CFG_W'(1));
		push_pixel(OBJECT_VALUE);
		push_pixel(8'd0);
		push_pixel(8'd254);
		wait_idle();

		// Zero sizes act as one
		set_frame(CFG_W'(0), CFG_W'(0));
		push_pixel(OBJECT_VALUE);
		push_pixel(8'd128);
		wait_idle();

		// Small frame with mixed pixels, then a full one
		set_frame(CFG_W'(3), CFG_W'(2));
		push_pixel(OBJECT_VALUE);
		push_pixel(8'd0);
		push_pixel(OBJECT_VALUE);
		push_pixel(8'd127);
		push_pixel(OBJECT_VALUE);
		push_pixel(OBJECT_VALUE);
		queue_frame(100);
		wait_idle();

		// Shrink the size mid-frame; the next pixel closes the frame
		set_frame(CFG_W'(4), CFG_W'(4));
		push_pixel(OBJECT_VALUE);
		push_pixel(8'd1);
		push_pixel(OBJECT_VALUE);
		push_pixel(8'd64);
		push_pixel(OBJECT_VALUE);
		wait_idle();
		set_frame(CFG_W'(2), CFG_W'(2));
		push_pixel(OBJECT_VALUE);
		wait_idle();

		// Sender idles less than the receiver
		random_frames(50);
		set_frame(CFG_W'(2047), CFG_W'(1));
		queue_frame(100);
		wait_idle();

		// Receiver idles less than the sender; tall frame at the height limits
		send_idle_pct = 58;
		recv_idle_pct = 22;
		random_frames(50);
		set_frame(CFG_W'(1), CFG_W'(2047));
		repeat (120)
			push_pixel($urandom_range(1) ? OBJECT_VALUE : 8'($urandom_range(0, 254)));
		wait_idle();
		set_frame(CFG_W'(1), CFG_W'(1024));
		repeat (80)
			push_pixel($urandom_range(1) ? OBJECT_VALUE : 8'($urandom_range(0, 254)));
		wait_idle();
		set_frame(CFG_W'(1), CFG_W'(2));
		push_pixel(OBJECT_VALUE);
		wait_idle();

		// No idling; then hold off results so the block backs up its input
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_frames(50);
		set_frame(CFG_W'(2), CFG_W'(2));
		hold_req = 1'b1;
		repeat (25)
			queue_frame(-1);
		wait_idle();

		if (fail_count == 0 && pending_moments.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
